[rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_CHK_RST(lbl, prop, msg)
`endif

`endif

[rtl/kcf_pkg.sv]
package kcf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int KERNEL    = 3;
  localparam int TAPS      = KERNEL * KERNEL;
  localparam int TAP_W     = $clog2(TAPS);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int HGT_W     = 16;
  localparam int ROW_W     = 17;
  localparam int CNT_W     = 26;
  localparam int IDX_W     = 27;
  localparam int DIV_W     = 27;
  localparam int DVS_W     = 11;
  localparam int SUM_W     = 20;
  localparam int COEF_W    = 7;
  localparam int PIX_W     = 32;
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int CHANS     = 3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF,
    CFG_OFFSET,
    CFG_DIVISOR,
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_ANCHOR_COL,
    CFG_ANCHOR_ROW
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_DEC,
    S_RD,
    S_SHIFT,
    S_CHK,
    S_XYW,
    S_FIT,
    S_MAC,
    S_DIV,
    S_DIVW,
    S_EMIT
  } kcf_state_t;

  typedef enum logic {
    DIV_XY,
    DIV_CHAN
  } div_mode_t;

  typedef struct packed {
    logic      load;
    logic      calc_idx;
    logic      restart;
    logic      shift;
    logic      div_start;
    div_mode_t div_mode;
    logic      xy_capture;
    logic      centre_capture;
    logic      mac_step;
    logic      ch_capture;
    logic [1:0] ch;
    logic      emit;
  } kcf_cmd_t;

  typedef struct packed {
    logic drop;
    logic emit_ok;
    logic fits;
    logic mac_last;
    logic div_busy;
    logic out_free;
  } kcf_status_t;

endpackage

[rtl/kcf_if.sv]
interface kcf_pix_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic [7:0] alpha_in;

  modport source (output valid, opcode, chan_a, chan_b, chan_c, alpha_in, input ready);
  modport sink (input valid, opcode, chan_a, chan_b, chan_c, alpha_in, output ready);
endinterface

interface kcf_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_a;
  logic [7:0] out_b;
  logic [7:0] out_c;
  logic [7:0] alpha_out;
  logic       frame_end;

  modport source (output valid, out_a, out_b, out_c, alpha_out, frame_end, input ready);
  modport sink (input valid, out_a, out_b, out_c, alpha_out, frame_end, output ready);
endinterface

[rtl/kcf_ram.sv]
module kcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kcf_div.sv]
module kcf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kcf_pkg::DIV_W-1:0]  dividend,
  input  logic [kcf_pkg::DVS_W-1:0]  divisor,
  output logic                       busy,
  output logic [kcf_pkg::DIV_W-1:0]  quo,
  output logic [kcf_pkg::DVS_W-1:0]  rem
);
  import kcf_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    count;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   partial;
  logic             ge;

  assign partial = {rem, quo[DIV_W-1]};
  assign ge      = partial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(DIV_W);
      quo   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= ge ? DVS_W'(partial - {1'b0, dvs}) : DVS_W'(partial);
      quo   <= {quo[DIV_W-2:0], ge};
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[rtl/kcf_dp.sv]
module kcf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kcf_pkg::kcf_cmd_t             cmd,
  output kcf_pkg::kcf_status_t          st,
  input  logic                          cfg_we,
  input  logic [kcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          opcode,
  input  logic [7:0]                    chan_a,
  input  logic [7:0]                    chan_b,
  input  logic [7:0]                    chan_c,
  input  logic [7:0]                    alpha_in,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [7:0]                    out_a,
  output logic [7:0]                    out_b,
  output logic [7:0]                    out_c,
  output logic [7:0]                    alpha_out,
  output logic                          frame_end
);
  import kcf_pkg::*;

  logic [CFG_W-1:0]        coef_r;
  logic signed [8:0]       offset_r;
  logic signed [DVS_W-1:0] fdiv_r;
  logic [WID_W-1:0]        width_r;
  logic [HGT_W-1:0]        height_r;
  logic [1:0]              acol_r;
  logic [1:0]              arow_r;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [1:0]       ac;
  logic [1:0]       ar;
  logic [1:0]       ac_m;
  logic [1:0]       ar_m;

  logic             op_r;
  logic [PIX_W-1:0] pix_r;
  logic [WID_W-1:0] w_r;
  logic [HGT_W-1:0] h_r;
  logic [CNT_W-1:0] total_r;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [CNT_W-1:0] out_count;
  logic [IDX_W-1:0] idx_r;
  logic [PIX_W-1:0] win [TAPS];
  logic [WID_W-1:0] x_r;
  logic [ROW_W-1:0] y_r;
  logic [PIX_W-1:0] centre_r;
  logic             fits_r;
  logic [TAP_W-1:0] tap;
  logic signed [SUM_W-1:0] sum_r [CHANS];
  logic signed [DVS_W-1:0] csum_r;
  logic [7:0]       res_r [CHANS];

  logic [2*PIX_W-1:0] rdata;
  logic [2*PIX_W-1:0] wdata;
  logic [PIX_W-1:0]   column [KERNEL];
  logic [WID_W:0]     col_inc;
  logic [WID_W:0]     lat;
  logic [TAP_W-1:0]   centre_idx;
  logic [TAP_W-1:0]   win_idx;
  logic [PIX_W-1:0]   win_rd;
  logic signed [COEF_W-1:0] coef;
  logic signed [DVS_W-1:0]  div_eff;
  logic [DVS_W-1:0]   div_abs;
  logic [SUM_W-1:0]   sum_abs;
  logic [DIV_W-1:0]   dv_dividend;
  logic [DVS_W-1:0]   dv_divisor;
  logic               dv_busy;
  logic [DIV_W-1:0]   dv_quo;
  logic [DVS_W-1:0]   dv_rem;
  logic               neg;
  logic [18:0]        qmag;
  logic signed [20:0] qval;
  logic signed [20:0] vval;
  logic [7:0]         clamped;
  logic               last;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_r   <= '0;
      offset_r <= '0;
      fdiv_r   <= '0;
      width_r  <= WID_W'(MAX_WIDTH);
      height_r <= HGT_W'(1);
      acol_r   <= 2'd1;
      arow_r   <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF:       coef_r   <= cfg_data;
        CFG_OFFSET:     offset_r <= cfg_data[8:0];
        CFG_DIVISOR:    fdiv_r   <= cfg_data[DVS_W-1:0];
        CFG_WIDTH:      width_r  <= cfg_data[WID_W-1:0];
        CFG_HEIGHT:     height_r <= cfg_data[HGT_W-1:0];
        CFG_ANCHOR_COL: acol_r   <= cfg_data[1:0];
        CFG_ANCHOR_ROW: arow_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? HGT_W'(1) : height_r;
    ac    = (acol_r > 2'(KERNEL - 1)) ? 2'(KERNEL - 1) : acol_r;
    ar    = (arow_r > 2'(KERNEL - 1)) ? 2'(KERNEL - 1) : arow_r;
    ac_m  = 2'(KERNEL - 1) - ac;
    ar_m  = 2'(KERNEL - 1) - ar;
  end

  always_comb begin
    case (ar_m)
      2'd2:    lat = {w_r, 1'b0};
      2'd1:    lat = {1'b0, w_r};
      default: lat = '0;
    endcase
    lat = lat + (WID_W + 1)'(ac_m);
  end

  assign column[0] = rdata[2*PIX_W-1:PIX_W];
  assign column[1] = rdata[PIX_W-1:0];
  assign column[2] = pix_r;
  assign wdata     = {rdata[PIX_W-1:0], pix_r};
  assign col_inc   = (WID_W + 1)'(in_col) + (WID_W + 1)'(1);

  kcf_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_rows (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (in_col),
    .wdata (wdata),
    .raddr (in_col),
    .rdata (rdata)
  );

  assign centre_idx = TAP_W'(ar) * TAP_W'(KERNEL) + TAP_W'(ac);
  assign win_idx    = cmd.centre_capture ? centre_idx : tap;
  assign win_rd     = win[win_idx];
  assign coef       = coef_r[tap * COEF_W +: COEF_W];

  always_comb begin
    if (fdiv_r != '0) begin
      div_eff = fdiv_r;
    end else if (csum_r == '0) begin
      div_eff = DVS_W'(1);
    end else begin
      div_eff = csum_r;
    end
    div_abs = div_eff[DVS_W-1] ? DVS_W'(-div_eff) : DVS_W'(div_eff);
    sum_abs = sum_r[cmd.ch][SUM_W-1] ? SUM_W'(-sum_r[cmd.ch]) : SUM_W'(sum_r[cmd.ch]);
    if (cmd.div_mode == DIV_XY) begin
      dv_dividend = DIV_W'(out_count);
      dv_divisor  = w_r;
    end else begin
      dv_dividend = DIV_W'(sum_abs);
      dv_divisor  = div_abs;
    end
  end

  kcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .busy     (dv_busy),
    .quo      (dv_quo),
    .rem      (dv_rem)
  );

  always_comb begin
    neg  = sum_r[cmd.ch][SUM_W-1] ^ div_eff[DVS_W-1];
    qmag = {1'b0, dv_quo[17:0]} + 19'((neg && (dv_rem != '0)) ? 1 : 0);
    qval = neg ? -21'(signed'({1'b0, qmag})) : 21'(signed'({1'b0, qmag}));
    vval = 21'(offset_r) + qval;
    if (vval < 0) begin
      clamped = 8'd0;
    end else if (vval > 21'sd255) begin
      clamped = 8'd255;
    end else begin
      clamped = vval[7:0];
    end
  end

  assign last = (out_count + CNT_W'(1)) == total_r;

  always_comb begin
    st.drop     = (op_r == OP_FLUSH) &&
                  ((idx_r < {1'b0, total_r}) || (out_count >= total_r));
    st.emit_ok  = (out_count < total_r) &&
                  (({1'b0, out_count} + IDX_W'(lat)) <= idx_r);
    st.fits     = (x_r >= WID_W'(ac)) && (y_r >= ROW_W'(ar)) &&
                  (({1'b0, x_r} + (WID_W + 1)'(ac_m)) < {1'b0, w_r}) &&
                  (({1'b0, y_r} + (ROW_W + 1)'(ar_m)) < (ROW_W + 1)'(h_r));
    st.mac_last = tap == TAP_W'(TAPS - 1);
    st.div_busy = dv_busy;
    st.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col    <= '0;
      in_row    <= '0;
      out_count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        op_r    <= opcode;
        pix_r   <= (opcode == OP_FLUSH) ? '0 : {alpha_in, chan_c, chan_b, chan_a};
        w_r     <= w_eff;
        h_r     <= h_eff;
        total_r <= CNT_W'(w_eff * h_eff);
        if ((WID_W)'(in_col) >= w_eff) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end
      end
      if (cmd.calc_idx) begin
        idx_r <= IDX_W'(in_row * w_r) + IDX_W'(in_col);
      end
      if (cmd.restart && (op_r == OP_PIXEL) && (idx_r >= {1'b0, total_r})) begin
        in_col    <= '0;
        in_row    <= '0;
        out_count <= '0;
        idx_r     <= '0;
      end
      if (cmd.shift) begin
        for (int r = 0; r < KERNEL; r++) begin
          for (int c = 0; c < KERNEL - 1; c++) begin
            win[r * KERNEL + c] <= win[r * KERNEL + c + 1];
          end
          win[r * KERNEL + KERNEL - 1] <= column[r];
        end
        if (col_inc >= {1'b0, w_r}) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= col_inc[COL_W-1:0];
        end
      end
      if (cmd.xy_capture) begin
        x_r <= dv_rem;
        y_r <= dv_quo[ROW_W-1:0];
      end
      if (cmd.centre_capture) begin
        centre_r <= win_rd;
        fits_r   <= st.fits;
        tap      <= '0;
        csum_r   <= '0;
        for (int i = 0; i < CHANS; i++) begin
          sum_r[i] <= '0;
        end
      end
      if (cmd.mac_step) begin
        for (int i = 0; i < CHANS; i++) begin
          sum_r[i] <= sum_r[i] + SUM_W'(coef * signed'({1'b0, win_rd[8*i +: 8]}));
        end
        csum_r <= csum_r + DVS_W'(coef);
        tap    <= tap + TAP_W'(1);
      end
      if (cmd.ch_capture) begin
        res_r[cmd.ch] <= clamped;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_a     <= fits_r ? res_r[0] : centre_r[7:0];
        out_b     <= fits_r ? res_r[1] : centre_r[15:8];
        out_c     <= fits_r ? res_r[2] : centre_r[23:16];
        alpha_out <= centre_r[31:24];
        frame_end <= last;
        if (last) begin
          in_col    <= '0;
          in_row    <= '0;
          out_count <= '0;
        end else begin
          out_count <= out_count + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/kcf_ctl.sv]
`include "assert_macros.svh"

module kcf_ctl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kcf_pkg::kcf_status_t st,
  output kcf_pkg::kcf_cmd_t    cmd
);
  import kcf_pkg::*;

  kcf_state_t state;
  kcf_state_t state_next;
  logic [1:0] ch;
  logic [1:0] ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next   = state;
    ch_next      = ch;
    cmd          = '0;
    cmd.ch       = ch;
    cmd.div_mode = DIV_CHAN;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_POS;
        end
      end
      S_POS: begin
        cmd.calc_idx = 1'b1;
        state_next   = S_DEC;
      end
      S_DEC: begin
        if (st.drop) begin
          state_next = S_IDLE;
        end else begin
          cmd.restart = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: state_next = S_SHIFT;
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (st.emit_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_mode  = DIV_XY;
          state_next    = S_XYW;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_XYW: begin
        cmd.div_mode = DIV_XY;
        if (!st.div_busy) begin
          cmd.xy_capture = 1'b1;
          state_next     = S_FIT;
        end
      end
      S_FIT: begin
        cmd.centre_capture = 1'b1;
        ch_next            = '0;
        state_next         = st.fits ? S_MAC : S_EMIT;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (st.mac_last) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (!st.div_busy) begin
          cmd.ch_capture = 1'b1;
          if (ch == 2'(CHANS - 1)) begin
            state_next = S_EMIT;
          end else begin
            ch_next    = ch + 2'd1;
            state_next = S_DIV;
          end
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_CHK(a_emit_free, cmd.emit |-> st.out_free, "result written over a waiting one")
  `ASSERT_CHK(a_div_idle, cmd.div_start |-> !st.div_busy, "divider restarted while busy")
  `ASSERT_CHK(a_load_next, (in_valid && in_ready) |=> (state == S_POS), "request not taken up")
  `ASSERT_CHK_RST(a_rst_idle, rst |=> (state == S_IDLE), "controller not idle after reset")

endmodule

[rtl/kernel_convolution_filter_unit.sv]
// Channel   Dir   Handshake      Payload
// pix_in    in    valid/ready    opcode, chan_a, chan_b, chan_c, alpha_in
// pix_out   out   valid/ready    out_a, out_b, out_c, alpha_out, frame_end
// cfg       in    cfg_we         cfg_index, cfg_data
//
// One request at a time: a new request is accepted only once the controller is
// back in idle, be it a dropped flush, a request that yields no result, a border
// pixel or a filtered pixel. The shared 27-step restoring divider does the
// division: one pass gives the output column and row, one pass per colour
// channel gives the quotient.
// Reset is synchronous; the row store is not cleared.
// A waiting result holds the controller in its last state until taken.
module kernel_convolution_filter_unit (
  input  logic                          clk,
  input  logic                          rst,
  kcf_pix_in_if.sink                    pix_in,
  kcf_pix_out_if.source                 pix_out,
  input  logic                          cfg_we,
  input  logic [kcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcf_pkg::CFG_W-1:0]     cfg_data
);
  import kcf_pkg::*;

  kcf_cmd_t    cmd;
  kcf_status_t st;
  logic        in_ready;

  assign pix_in.ready = in_ready;

  kcf_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  kcf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (pix_in.opcode),
    .chan_a    (pix_in.chan_a),
    .chan_b    (pix_in.chan_b),
    .chan_c    (pix_in.chan_c),
    .alpha_in  (pix_in.alpha_in),
    .out_ready (pix_out.ready),
    .out_valid (pix_out.valid),
    .out_a     (pix_out.out_a),
    .out_b     (pix_out.out_b),
    .out_c     (pix_out.out_c),
    .alpha_out (pix_out.alpha_out),
    .frame_end (pix_out.frame_end)
  );

endmodule

[tb/sv/kernel_convolution_filter_unit_tb.sv]
module kernel_convolution_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kcf_pkg::*;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] alpha;
    logic       fend;
  } pixel_result_t;

  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  kcf_pix_in_if in_ch ();
  kcf_pix_out_if out_ch ();

  kernel_convolution_filter_unit dut (
    .clk(clk), .rst(rst), .pix_in(in_ch), .pix_out(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic [62:0] coef_r;
  logic [8:0] offset_r;
  logic [10:0] divisor_r;
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [1:0] acol_r;
  logic [1:0] arow_r;
  logic [31:0] line_mem [0:2*MAX_WIDTH-1];
  logic [31:0] win [0:2][0:2];
  longint col_pos, row_pos, emitted;

  pixel_result_t expected_pixels[$];
  bit failed = 1'b0;
  bit idle_en = 1'b1;
  int pixels_sent = 0;
  int quiet_cycles = 0;
  int ready_hold = 0;

  function automatic longint eff_w();
    if (width_r == 0) return 1;
    if (width_r > MAX_WIDTH) return MAX_WIDTH;
    return width_r;
  endfunction

  function automatic longint eff_h();
    return (height_r == 0) ? 1 : height_r;
  endfunction

  function automatic int sat_anchor(logic [1:0] a);
    return (a > 2) ? 2 : a;
  endfunction

  function automatic logic [7:0] filter_byte(int sh);
    longint sum, csum, k, dv, q, v;
    sum = 0;
    csum = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        k = longint'($signed(coef_r[7*(r*3+c) +: 7]));
        sum += k * longint'((win[r][c] >> sh) & 32'hFF);
        csum += k;
      end
    end
    dv = longint'($signed(divisor_r));
    if (dv == 0) dv = (csum == 0) ? 1 : csum;
    q = sum / dv;
    if ((sum % dv) != 0 && ((sum < 0) != (dv < 0))) q--;
    v = longint'($signed(offset_r)) + q;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic bit tail_pending();
    longint w, c, r;
    w = eff_w();
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    return (r * w + c >= w * eff_h()) && (emitted < w * eff_h());
  endfunction

  function automatic void predict_request(logic op, logic [31:0] pix_in);
    longint w, h, total, lat, idx, x, y, cc;
    int ac, ar;
    logic [31:0] p, centre;
    logic [31:0] column [0:2];
    bit fits, last;
    pixel_result_t res;
    w = eff_w();
    h = eff_h();
    total = w * h;
    ac = sat_anchor(acol_r);
    ar = sat_anchor(arow_r);
    lat = (2 - ar) * w + (2 - ac);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    idx = row_pos * w + col_pos;
    if (op == OP_FLUSH) begin
      if (idx < total || emitted >= total) return;
      p = '0;
    end else begin
      if (idx >= total) begin
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
        idx = 0;
      end
      p = pix_in;
    end
    cc = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    column[2] = p;
    column[1] = line_mem[cc];
    column[0] = line_mem[MAX_WIDTH + cc];
    line_mem[cc] = column[2];
    line_mem[MAX_WIDTH + cc] = column[1];
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
      win[r][2] = column[r];
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (emitted >= total || emitted + lat > idx) return;
    x = emitted % w;
    y = emitted / w;
    fits = x >= ac && y >= ar && x + (2 - ac) < w && y + (2 - ar) < h;
    centre = win[ar][ac];
    if (fits) begin
      res.a = filter_byte(0);
      res.b = filter_byte(8);
      res.c = filter_byte(16);
    end else begin
      res.a = centre[7:0];
      res.b = centre[15:8];
      res.c = centre[23:16];
    end
    res.alpha = centre[31:24];
    last = (emitted + 1 == total);
    res.fend = last;
    expected_pixels = {expected_pixels, res};
    emitted++;
    if (last) begin
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
    end
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_COEF: coef_r = value[62:0];
      CFG_OFFSET: offset_r = value[8:0];
      CFG_DIVISOR: divisor_r = value[10:0];
      CFG_WIDTH: width_r = value[10:0];
      CFG_HEIGHT: height_r = value[15:0];
      CFG_ANCHOR_COL: acol_r = value[1:0];
      CFG_ANCHOR_ROW: arow_r = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                              logic [7:0] al);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.chan_a <= a;
    in_ch.chan_b <= b;
    in_ch.chan_c <= c;
    in_ch.alpha_in <= al;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(op, {al, c, b, a});
    if (op == OP_PIXEL) pixels_sent++;
  endtask

  task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] al);
    send_request(OP_PIXEL, a, b, c, al);
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_random_flush();
    send_request(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain_tail();
    while (tail_pending()) send_random_flush();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_frame(logic [62:0] coef, logic [8:0] offs, logic [10:0] dv,
                           logic [10:0] w, logic [15:0] h, logic [1:0] ac, logic [1:0] ar);
    write_reg(CFG_COEF, CFG_W'(coef));
    write_reg(CFG_OFFSET, CFG_W'(offs));
    write_reg(CFG_DIVISOR, CFG_W'(dv));
    write_reg(CFG_WIDTH, CFG_W'(w));
    write_reg(CFG_HEIGHT, CFG_W'(h));
    write_reg(CFG_ANCHOR_COL, CFG_W'(ac));
    write_reg(CFG_ANCHOR_ROW, CFG_W'(ar));
  endtask

  function automatic logic [62:0] uniform_coef(logic [6:0] k);
    logic [62:0] v;
    v = '0;
    for (int j = 0; j < TAPS; j++) v[7*j +: 7] = k;
    return v;
  endfunction

  task automatic test_directed();
    set_frame(uniform_coef(7'd1), 9'd0, 11'd0, 11'd4, 16'd3, 2'd1, 2'd1);
    send_request(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    for (int i = 0; i < 10; i++) send_pixel(8'hFF, 8'hFF, 8'h00, 8'h55);
    drain_tail();
    send_request(OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_idle();
    set_frame(uniform_coef(7'h40), 9'h100, 11'h400, 11'd3, 16'd3, 2'd3, 2'd3);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'h00, 8'h80, i[7:0]);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_frame(uniform_coef(7'h3F), 9'h0FF, 11'h3FF, 11'd0, 16'hFFFF, 2'd0, 2'd0);
    write_reg(CFG_HEIGHT, CFG_W'(16'd0));
    for (int i = 0; i < 2; i++) send_random_pixel();
    wait_idle();
    set_frame(63'h7FFF_FFFF_FFFF_FFFF, 9'h101, 11'h7FF, 11'h7FF, 16'd1, 2'd2, 2'd2);
    for (int i = 0; i < 8; i++) send_random_pixel();
    wait_idle();
    write_reg(CFG_WIDTH, CFG_W'(11'd1));
    send_random_pixel();
    wait_idle();
  endtask

  task automatic test_random_frames(int target);
    bit drained;
    int w, h, kind;
    drained = 1'b1;
    while (pixels_sent < target) begin
      if (pixels_sent > target - 60) idle_en = 1'b0;
      if (drained) begin
        wait_idle();
        kind = $urandom_range(0, 9);
        w = (kind == 0) ? $urandom_range(1, 40) : $urandom_range(3, 8);
        h = (kind == 1) ? $urandom_range(0, 2) : $urandom_range(3, 5);
        set_frame(kind == 2 ? uniform_coef($urandom_range(0, 1) ? 7'h40 : 7'h3F)
                            : 63'({$urandom, $urandom}),
                  9'($urandom), (kind < 4) ? 11'd0 : 11'($urandom),
                  11'(w), 16'(h), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
      for (int i = 0; i < eff_w() * eff_h(); i++) begin
        if ($urandom_range(0, 15) == 0)
          send_random_flush();
        send_random_pixel();
      end
      drained = ($urandom_range(0, 9) != 0);
      if (drained) begin
        drain_tail();
        if ($urandom_range(0, 3) == 0)
          send_random_flush();
      end
    end
    drain_tail();
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result out_a %0d", out_ch.out_a);
        failed = 1'b1;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_ch.out_a !== exp_px.a) begin
          $error("out_a expected %0d got %0d", exp_px.a, out_ch.out_a);
          failed = 1'b1;
        end
        if (out_ch.out_b !== exp_px.b) begin
          $error("out_b expected %0d got %0d", exp_px.b, out_ch.out_b);
          failed = 1'b1;
        end
        if (out_ch.out_c !== exp_px.c) begin
          $error("out_c expected %0d got %0d", exp_px.c, out_ch.out_c);
          failed = 1'b1;
        end
        if (out_ch.alpha_out !== exp_px.alpha) begin
          $error("alpha_out expected %0d got %0d", exp_px.alpha, out_ch.alpha_out);
          failed = 1'b1;
        end
        if (out_ch.frame_end !== exp_px.fend) begin
          $error("frame_end expected %0d got %0d", exp_px.fend, out_ch.frame_end);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PIXEL;
    in_ch.chan_a = '0;
    in_ch.chan_b = '0;
    in_ch.chan_c = '0;
    in_ch.alpha_in = '0;
    coef_r = '0;
    offset_r = '0;
    divisor_r = '0;
    width_r = 11'd1024;
    height_r = 16'd1;
    acol_r = 2'd1;
    arow_r = 2'd1;
    for (int i = 0; i < 2 * MAX_WIDTH; i++) line_mem[i] = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_random_frames(pixels_sent + 320);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (200) @(posedge clk);
    if (!failed && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
